/* rtl/gwwl_pkg.sv */
package gwwl_pkg;

	// layout limits
	localparam int MAX_CHARS   = 32;
	localparam int LINE_LIMIT  = 4;
	localparam int LENW        = $clog2(MAX_CHARS + 1);
	localparam int IDXW        = $clog2(MAX_CHARS);
	localparam int QBITS       = $clog2(MAX_CHARS);
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTRW   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNTW   = $clog2(FIFO_DEPTH + 1);
	localparam int RAM_DEPTH   = 2 * MAX_CHARS;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);

	// character codes
	localparam logic [7:0] CHAR_END   = 8'd0;
	localparam logic [7:0] CHAR_SPACE = 8'd32;

	// line pitch is font height plus this gap
	localparam logic [8:0] PITCH_GAP = 9'd5;

	// register values after reset
	localparam logic [10:0] RST_TEXT_WIDTH   = 11'd800;
	localparam logic [7:0]  RST_GLYPH_WIDTH  = 8'd8;
	localparam logic [7:0]  RST_GLYPH_HEIGHT = 8'd16;
	localparam logic [10:0] RST_X_ORIGIN     = 11'd0;
	localparam logic [10:0] RST_Y_ORIGIN     = 11'd0;
	localparam logic        RST_CENTER       = 1'b0;
	localparam int RST_CPL_RAW = 800 / 8;
	localparam int RST_CPL     = (RST_CPL_RAW > MAX_CHARS) ? MAX_CHARS : RST_CPL_RAW;

	typedef enum logic [2:0] {
		REG_TEXT_WIDTH   = 3'd0,
		REG_GLYPH_WIDTH  = 3'd1,
		REG_GLYPH_HEIGHT = 3'd2,
		REG_X_ORIGIN     = 3'd3,
		REG_Y_ORIGIN     = 3'd4,
		REG_CENTER       = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_LINE = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [10:0] text_width;
		logic [7:0]  glyph_width;
		logic [7:0]  glyph_height;
		logic [10:0] x_origin;
		logic [10:0] y_origin;
		logic        center;
	} cfg_t;

	// one finished word or end of message, handed from front to back
	typedef struct packed {
		logic            is_end;
		logic [LENW-1:0] len;
		logic            bank;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  line_num;
		logic [5:0]  column;
		logic [7:0]  glyph;
		logic [15:0] dx;
		logic [15:0] dy;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		CPL_IDLE,
		CPL_CHECK,
		CPL_ITER
	} cpl_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FLUSH,
		B_PREP,
		B_CHARS,
		B_ENDCHK,
		B_DONE
	} back_state_t;

endpackage

/* rtl/gwwl_ram.sv */
module gwwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/gwwl_cpl.sv */
module gwwl_cpl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  gwwl_pkg::cfg_t                cfg,
	output logic [gwwl_pkg::LENW-1:0]     cpl,
	output logic                          busy
);

	gwwl_pkg::cpl_state_t state_q, state_d;
	logic [10:0]                  rem_q;
	logic [gwwl_pkg::QBITS-1:0]   quo_q;
	logic [2:0]                   bit_q;
	logic [gwwl_pkg::LENW-1:0]    cpl_q;

	logic [13:0]                  width_cap;
	logic                         saturate;
	logic [12:0]                  trial;
	logic                         take;
	logic [gwwl_pkg::QBITS-1:0]   quo_d;

	// saturation test and one restoring step
	assign width_cap = 14'(cfg.glyph_width) * 14'(gwwl_pkg::MAX_CHARS);
	assign saturate  = (cfg.glyph_width == 8'd0) || ({3'b0, cfg.text_width} >= width_cap);
	assign trial     = 13'(cfg.glyph_width) << bit_q;
	assign take      = {2'b0, rem_q} >= trial;
	assign quo_d     = take ? (quo_q | (gwwl_pkg::QBITS'(1) << bit_q)) : quo_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gwwl_pkg::CPL_IDLE: begin
				state_d = gwwl_pkg::CPL_IDLE;
			end
			gwwl_pkg::CPL_CHECK: begin
				state_d = saturate ? gwwl_pkg::CPL_IDLE : gwwl_pkg::CPL_ITER;
			end
			gwwl_pkg::CPL_ITER: begin
				state_d = (bit_q == 3'd0) ? gwwl_pkg::CPL_IDLE : gwwl_pkg::CPL_ITER;
			end
			default: begin
				state_d = gwwl_pkg::CPL_IDLE;
			end
		endcase
		if (start) begin
			state_d = gwwl_pkg::CPL_CHECK;
		end
	end

	// outputs
	always_comb begin
		case (state_q)
			gwwl_pkg::CPL_IDLE: busy = 1'b0;
			default:            busy = 1'b1;
		endcase
	end

	assign cpl = cpl_q;

	// state and quotient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwwl_pkg::CPL_IDLE;
			cpl_q   <= gwwl_pkg::LENW'(gwwl_pkg::RST_CPL);
		end else begin
			state_q <= state_d;
			if (!start) begin
				if (state_q == gwwl_pkg::CPL_CHECK && saturate) begin
					cpl_q <= gwwl_pkg::LENW'(gwwl_pkg::MAX_CHARS);
				end else if (state_q == gwwl_pkg::CPL_ITER && bit_q == 3'd0) begin
					cpl_q <= gwwl_pkg::LENW'(quo_d);
				end
			end
		end
	end

	// datapath of the shift-subtract divider
	always_ff @(posedge clk) begin
		case (state_q)
			gwwl_pkg::CPL_CHECK: begin
				rem_q <= cfg.text_width;
				quo_q <= '0;
				bit_q <= 3'(gwwl_pkg::QBITS - 1);
			end
			gwwl_pkg::CPL_ITER: begin
				if (take) begin
					rem_q <= 11'({2'b0, rem_q} - trial);
				end
				quo_q <= quo_d;
				bit_q <= bit_q - 3'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/gwwl_front.sv */
module gwwl_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      char_code,
	input  logic                            hold,
	input  logic [gwwl_pkg::LENW-1:0]       cpl,
	input  logic                            cmd_done,
	output logic                            wr_en,
	output logic [gwwl_pkg::RAM_AW-1:0]     wr_addr,
	output logic [7:0]                      wr_data,
	output logic                            push,
	output gwwl_pkg::cmd_t                  push_cmd
);

	logic [gwwl_pkg::LENW-1:0]      len_q;
	logic                           bank_q;
	logic [gwwl_pkg::FIFO_CNTW-1:0] pend_q;
	logic                           xfer;
	logic                           is_end;
	logic                           is_space;
	logic                           has_word;

	// one word bank per outstanding command, so stall once both are held
	assign s_tready = !hold && (pend_q < gwwl_pkg::FIFO_CNTW'(gwwl_pkg::FIFO_DEPTH));
	assign xfer     = s_tvalid && s_tready;

	// classify the byte
	assign is_end   = char_code == gwwl_pkg::CHAR_END;
	assign is_space = char_code == gwwl_pkg::CHAR_SPACE;
	assign has_word = len_q != '0;

	// word characters go to the current bank while there is room on a line
	assign wr_en   = xfer && !is_end && !is_space && (len_q < cpl);
	assign wr_addr = {bank_q, len_q[gwwl_pkg::IDXW-1:0]};
	assign wr_data = char_code;

	// end of message is always queued, a space only after a word
	assign push            = xfer && (is_end || (is_space && has_word));
	assign push_cmd.is_end = is_end;
	assign push_cmd.len    = len_q;
	assign push_cmd.bank   = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			bank_q <= 1'b0;
			pend_q <= '0;
		end else begin
			if (wr_en) begin
				len_q <= len_q + gwwl_pkg::LENW'(1);
			end
			if (push) begin
				len_q <= '0;
				if (has_word) begin
					bank_q <= !bank_q;
				end
			end
			if (push && !cmd_done) begin
				pend_q <= pend_q + gwwl_pkg::FIFO_CNTW'(1);
			end else if (!push && cmd_done) begin
				pend_q <= pend_q - gwwl_pkg::FIFO_CNTW'(1);
			end
		end
	end

endmodule

/* rtl/gwwl_fifo.sv */
module gwwl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gwwl_pkg::cmd_t push_cmd,
	input  logic           pop,
	output gwwl_pkg::cmd_t head,
	output logic           empty
);

	gwwl_pkg::cmd_t                 slot_q [gwwl_pkg::FIFO_DEPTH];
	logic [gwwl_pkg::FIFO_PTRW-1:0] wr_ptr_q;
	logic [gwwl_pkg::FIFO_PTRW-1:0] rd_ptr_q;
	logic [gwwl_pkg::FIFO_CNTW-1:0] count_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = count_q == '0;

	// slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gwwl_pkg::FIFO_PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gwwl_pkg::FIFO_PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + gwwl_pkg::FIFO_CNTW'(1);
			end else if (!push && pop) begin
				count_q <= count_q - gwwl_pkg::FIFO_CNTW'(1);
			end
		end
	end

endmodule

/* rtl/gwwl_back.sv */
module gwwl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gwwl_pkg::cfg_t                cfg,
	input  logic [gwwl_pkg::LENW-1:0]     cpl,
	input  logic                          fifo_empty,
	input  gwwl_pkg::cmd_t                fifo_head,
	output logic                          pop,
	output logic                          cmd_done,
	output logic                          rd_en,
	output logic [gwwl_pkg::RAM_AW-1:0]   rd_addr,
	input  logic [7:0]                    rd_data,
	output logic                          m_valid,
	input  logic                          m_ready,
	output gwwl_pkg::result_t             m_res
);

	gwwl_pkg::back_state_t     state_q, state_d;
	gwwl_pkg::cmd_t            cmd_q;
	logic [gwwl_pkg::LENW-1:0] wl_q;
	logic [gwwl_pkg::LENW-1:0] k_q;
	logic [gwwl_pkg::LENW-1:0] k_next;
	logic [2:0]                idx_q;
	logic [gwwl_pkg::LENW-1:0] fill_q;
	logic                      full_q;
	logic                      m_valid_q;
	gwwl_pkg::result_t         res_q;

	logic                      adv;
	logic                      want;
	gwwl_pkg::result_t         res;
	logic                      wl_zero;
	logic                      has_fill;
	logic                      wrap;
	logic                      last_line;
	logic                      last_char;
	logic [gwwl_pkg::LENW:0]   need;
	logic [13:0]               line_px;
	logic [10:0]               slack;
	logic [15:0]               line_x;
	logic [8:0]                pitch;
	logic [11:0]               y_step;
	logic [15:0]               line_y;
	gwwl_pkg::result_t         rec_line;
	gwwl_pkg::result_t         rec_char;

	// output register advances when empty or being taken
	assign adv = !m_valid_q || m_ready;

	// placement tests
	assign wl_zero   = (wl_q == '0) || full_q;
	assign has_fill  = fill_q != '0;
	assign need      = (gwwl_pkg::LENW + 1)'(fill_q) + (gwwl_pkg::LENW + 1)'(1)
		+ (gwwl_pkg::LENW + 1)'(wl_q);
	assign wrap      = has_fill && (need > (gwwl_pkg::LENW + 1)'(cpl));
	assign last_line = ({1'b0, idx_q} + 4'd1) >= 4'(gwwl_pkg::LINE_LIMIT);
	assign k_next    = k_q + gwwl_pkg::LENW'(1);
	assign last_char = k_next == wl_q;

	// line geometry
	assign line_px = 14'(fill_q) * 14'(cfg.glyph_width);
	assign slack   = cfg.text_width - line_px[10:0];
	assign line_x  = (cfg.center && (line_px < {3'b0, cfg.text_width}))
		? 16'(cfg.x_origin) + 16'(slack >> 1) : 16'(cfg.x_origin);
	assign pitch   = {1'b0, cfg.glyph_height} + gwwl_pkg::PITCH_GAP;
	assign y_step  = 12'(idx_q) * 12'(pitch);
	assign line_y  = 16'(cfg.y_origin) + 16'(y_step);

	// line record and placed character templates
	always_comb begin
		rec_line          = '0;
		rec_line.kind     = gwwl_pkg::KIND_LINE;
		rec_line.line_num = idx_q;
		rec_line.column   = 6'(fill_q);
		rec_line.dx       = line_x;
		rec_line.dy       = line_y;
		rec_char          = '0;
		rec_char.kind     = gwwl_pkg::KIND_CHAR;
		rec_char.line_num = idx_q;
		rec_char.column   = 6'(fill_q);
		rec_char.dy       = line_y;
	end

	// outputs of the sequencer
	always_comb begin
		want     = 1'b0;
		res      = rec_char;
		pop      = 1'b0;
		cmd_done = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = {cmd_q.bank, k_q[gwwl_pkg::IDXW-1:0]};
		case (state_q)
			gwwl_pkg::B_IDLE: begin
				pop = !fifo_empty;
			end
			gwwl_pkg::B_FLUSH: begin
				if (!wl_zero && wrap) begin
					want     = 1'b1;
					res      = rec_line;
					res.last = !cmd_q.is_end && last_line;
				end else if (!wl_zero && has_fill) begin
					want      = 1'b1;
					res       = rec_char;
					res.glyph = gwwl_pkg::CHAR_SPACE;
				end
			end
			gwwl_pkg::B_PREP: begin
				rd_en   = 1'b1;
				rd_addr = {cmd_q.bank, {gwwl_pkg::IDXW{1'b0}}};
			end
			gwwl_pkg::B_CHARS: begin
				want      = 1'b1;
				res       = rec_char;
				res.glyph = rd_data;
				res.last  = !cmd_q.is_end && last_char;
				rd_en     = adv;
				rd_addr   = {cmd_q.bank, k_next[gwwl_pkg::IDXW-1:0]};
			end
			gwwl_pkg::B_ENDCHK: begin
				if (!cmd_q.is_end) begin
					cmd_done = 1'b1;
				end else if (!full_q && has_fill) begin
					want = 1'b1;
					res  = rec_line;
				end
			end
			gwwl_pkg::B_DONE: begin
				want          = 1'b1;
				res           = '0;
				res.kind      = gwwl_pkg::KIND_DONE;
				res.line_num  = idx_q;
				res.last      = 1'b1;
				cmd_done      = adv;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gwwl_pkg::B_IDLE: begin
				if (!fifo_empty) begin
					state_d = gwwl_pkg::B_FLUSH;
				end
			end
			gwwl_pkg::B_FLUSH: begin
				if (wl_zero) begin
					state_d = gwwl_pkg::B_ENDCHK;
				end else if (wrap) begin
					if (adv && last_line) begin
						state_d = gwwl_pkg::B_ENDCHK;
					end
				end else if (has_fill) begin
					if (adv) begin
						state_d = gwwl_pkg::B_PREP;
					end
				end else begin
					state_d = gwwl_pkg::B_PREP;
				end
			end
			gwwl_pkg::B_PREP: begin
				state_d = gwwl_pkg::B_CHARS;
			end
			gwwl_pkg::B_CHARS: begin
				if (adv && last_char) begin
					state_d = gwwl_pkg::B_ENDCHK;
				end
			end
			gwwl_pkg::B_ENDCHK: begin
				if (!cmd_q.is_end) begin
					state_d = gwwl_pkg::B_IDLE;
				end else if (!full_q && has_fill) begin
					if (adv) begin
						state_d = gwwl_pkg::B_DONE;
					end
				end else begin
					state_d = gwwl_pkg::B_DONE;
				end
			end
			gwwl_pkg::B_DONE: begin
				if (adv) begin
					state_d = gwwl_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = gwwl_pkg::B_IDLE;
			end
		endcase
	end

	// line position state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gwwl_pkg::B_IDLE;
			idx_q     <= '0;
			fill_q    <= '0;
			full_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				m_valid_q <= want;
			end
			case (state_q)
				gwwl_pkg::B_FLUSH: begin
					if (!wl_zero && wrap && adv) begin
						idx_q  <= idx_q + 3'd1;
						fill_q <= '0;
						if (last_line) begin
							full_q <= 1'b1;
						end
					end else if (!wl_zero && has_fill && adv) begin
						fill_q <= fill_q + gwwl_pkg::LENW'(1);
					end
				end
				gwwl_pkg::B_CHARS: begin
					if (adv) begin
						fill_q <= fill_q + gwwl_pkg::LENW'(1);
					end
				end
				gwwl_pkg::B_ENDCHK: begin
					if (cmd_q.is_end && !full_q && has_fill && adv) begin
						idx_q  <= idx_q + 3'd1;
						fill_q <= '0;
					end
				end
				gwwl_pkg::B_DONE: begin
					if (adv) begin
						idx_q  <= '0;
						fill_q <= '0;
						full_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result data, command, word length and replay index
	always_ff @(posedge clk) begin
		if (adv && want) begin
			res_q <= res;
		end
		if (pop) begin
			cmd_q <= fifo_head;
			wl_q  <= (fifo_head.len > cpl) ? cpl : fifo_head.len;
		end
		if (state_q == gwwl_pkg::B_PREP) begin
			k_q <= '0;
		end else if (state_q == gwwl_pkg::B_CHARS && adv) begin
			k_q <= k_next;
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = res_q;

endmodule

/* rtl/greedy_word_wrap_layout.sv */
// Greedy word-wrap layout. Message bytes enter on the slave stream, one byte per transfer:
// 0 ends a message, 32 separates words, anything else is a word character. The front end
// writes each word character into one of two word banks; a separator queues the finished
// word for the back end, which replays it from the bank and sends one result per cycle
// while the output is taken: the separating space, each character, a line record after
// each full line and after a partly filled last line, and a done record at message end.
// Per word the back end adds a dequeue, a bank read start and an end check step to its
// results, and one more step when the word opens a line, so with typical words the
// sustained byte rate is set by the back end's replay sequencer and the single bank read
// port. Two finished words or message ends may be outstanding; while both are held, input
// stalls until the back end finishes one. After any register write the input is held while
// the characters-per-line limit is recomputed by a shift-subtract divider. No clearing pass
// is needed after reset.
module greedy_word_wrap_layout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // line_num[2:0], column[8:3], glyph_code[16:9],
	                               // draw_x[32:17], draw_y[48:33], zero fill
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	gwwl_pkg::cfg_t                 cfg_q;
	logic [gwwl_pkg::LENW-1:0]      cpl;
	logic                           cpl_busy;
	logic                           wr_en;
	logic [gwwl_pkg::RAM_AW-1:0]    wr_addr;
	logic [7:0]                     wr_data;
	logic                           rd_en;
	logic [gwwl_pkg::RAM_AW-1:0]    rd_addr;
	logic [7:0]                     rd_data;
	logic                           push;
	gwwl_pkg::cmd_t                 push_cmd;
	logic                           pop;
	gwwl_pkg::cmd_t                 fifo_head;
	logic                           fifo_empty;
	logic                           cmd_done;
	gwwl_pkg::result_t              res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_width   <= gwwl_pkg::RST_TEXT_WIDTH;
			cfg_q.glyph_width  <= gwwl_pkg::RST_GLYPH_WIDTH;
			cfg_q.glyph_height <= gwwl_pkg::RST_GLYPH_HEIGHT;
			cfg_q.x_origin     <= gwwl_pkg::RST_X_ORIGIN;
			cfg_q.y_origin     <= gwwl_pkg::RST_Y_ORIGIN;
			cfg_q.center       <= gwwl_pkg::RST_CENTER;
		end else if (cfg_we) begin
			case (cfg_index)
				gwwl_pkg::REG_TEXT_WIDTH:   cfg_q.text_width   <= cfg_data;
				gwwl_pkg::REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[7:0];
				gwwl_pkg::REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[7:0];
				gwwl_pkg::REG_X_ORIGIN:     cfg_q.x_origin     <= cfg_data;
				gwwl_pkg::REG_Y_ORIGIN:     cfg_q.y_origin     <= cfg_data;
				gwwl_pkg::REG_CENTER:       cfg_q.center       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// characters per line
	gwwl_cpl u_cpl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.cfg    (cfg_q),
		.cpl    (cpl),
		.busy   (cpl_busy)
	);

	// byte intake and word buffering
	gwwl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.char_code (s_tdata),
		.hold      (cpl_busy || cfg_we),
		.cpl       (cpl),
		.cmd_done  (cmd_done),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// two word banks
	gwwl_ram #(
		.WIDTH (8),
		.DEPTH (gwwl_pkg::RAM_DEPTH)
	) u_words (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// word queue
	gwwl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (fifo_head),
		.empty    (fifo_empty)
	);

	// placement and result generation
	gwwl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cpl        (cpl),
		.fifo_empty (fifo_empty),
		.fifo_head  (fifo_head),
		.pop        (pop),
		.cmd_done   (cmd_done),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.m_valid    (m_tvalid),
		.m_ready    (m_tready),
		.m_res      (res)
	);

	// result packing
	assign m_tdata = {7'b0, res.dy, res.dx, res.glyph, res.column, res.line_num};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

/* sim/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // char_code[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // line_num[2:0], column[8:3], glyph_code[16:9],
	                              // draw_x[32:17], draw_y[48:33], zero fill
	logic [1:0]  m_tuser;         // kind[1:0]
	logic        m_tlast;

	greedy_word_wrap_layout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// message bytes waiting to go out, layout results still to arrive
	logic [7:0]          text_bytes[$];
	gwwl_pkg::result_t   layout_expected[$];
	gwwl_pkg::result_t   step_results[$];
	int         items_queued = 0;
	int         errors = 0;
	int         send_idle_pct = 10;
	int         recv_idle_pct = 87;

	// layout registers as the block should hold them
	logic [10:0] cfg_text_width = gwwl_pkg::RST_TEXT_WIDTH;
	logic [7:0]  cfg_glyph_width = gwwl_pkg::RST_GLYPH_WIDTH;
	logic [7:0]  cfg_glyph_height = gwwl_pkg::RST_GLYPH_HEIGHT;
	logic [10:0] cfg_x = gwwl_pkg::RST_X_ORIGIN;
	logic [10:0] cfg_y = gwwl_pkg::RST_Y_ORIGIN;
	logic        cfg_center = gwwl_pkg::RST_CENTER;
	logic [5:0]  chars_per_line = 6'(gwwl_pkg::RST_CPL);

	// message state of the layout
	logic [7:0] word_buf[gwwl_pkg::MAX_CHARS];
	logic [5:0] word_count = '0;
	logic [2:0] row = '0;
	logic [5:0] row_fill = '0;
	logic       rows_exhausted = 1'b0;

	function automatic logic [15:0] row_y(logic [2:0] r);
		return 16'(int'(cfg_y) + int'(r) * (int'(cfg_glyph_height)
			+ int'(gwwl_pkg::PITCH_GAP)));
	endfunction

	function automatic void push_result(gwwl_pkg::kind_t k, int ln, int col, int code, int dx,
		int dy);
		gwwl_pkg::result_t r;
		r.kind = k;
		r.line_num = 3'(ln);
		r.column = 6'(col);
		r.glyph = 8'(code);
		r.dx = 16'(dx);
		r.dy = 16'(dy);
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	// line record with optional centring
	function automatic void close_line();
		int used;
		int dx;
		used = int'(row_fill) * int'(cfg_glyph_width);
		dx = int'(cfg_x);
		if (cfg_center && used < int'(cfg_text_width))
			dx = int'(cfg_x) + (int'(cfg_text_width) - used) / 2;
		push_result(gwwl_pkg::KIND_LINE, row, row_fill, 0, dx, row_y(row));
	endfunction

	// greedy placement of the buffered word
	function automatic void place_word();
		int wl;
		int k;
		wl = int'(word_count);
		if (wl > int'(chars_per_line))
			wl = int'(chars_per_line);
		word_count = '0;
		if (wl == 0 || rows_exhausted)
			return;
		if (row_fill > 0 && int'(row_fill) + 1 + wl > int'(chars_per_line)) begin
			close_line();
			row = row + 3'd1;
			row_fill = '0;
			if (int'(row) >= gwwl_pkg::LINE_LIMIT) begin
				rows_exhausted = 1'b1;
				return;
			end
		end
		if (row_fill > 0) begin
			push_result(gwwl_pkg::KIND_CHAR, row, row_fill, gwwl_pkg::CHAR_SPACE, 0,
				row_y(row));
			row_fill = row_fill + 6'd1;
		end
		for (k = 0; k < wl; k++) begin
			push_result(gwwl_pkg::KIND_CHAR, row, row_fill, word_buf[gwwl_pkg::IDXW'(k)], 0,
				row_y(row));
			row_fill = row_fill + 6'd1;
		end
	endfunction

	// expected results for one accepted message byte
	function automatic void wrap_byte(logic [7:0] c);
		int count;
		int i;
		gwwl_pkg::result_t r;
		if (c != gwwl_pkg::CHAR_END && c != gwwl_pkg::CHAR_SPACE) begin
			if (word_count < chars_per_line && int'(word_count) < gwwl_pkg::MAX_CHARS) begin
				word_buf[word_count[gwwl_pkg::IDXW-1:0]] = c;
				word_count = word_count + 6'd1;
			end
			return;
		end
		place_word();
		if (c == gwwl_pkg::CHAR_END) begin
			count = int'(row);
			if (!rows_exhausted && row_fill > 0) begin
				close_line();
				count = int'(row) + 1;
			end
			push_result(gwwl_pkg::KIND_DONE, count, 0, 0, 0, 0);
			word_count = '0;
			row = '0;
			row_fill = '0;
			rows_exhausted = 1'b0;
		end
		for (i = 0; i < step_results.size(); i++) begin
			r = step_results[i];
			r.last = (i == step_results.size() - 1);
			layout_expected.push_back(r);
		end
		step_results.delete();
	endfunction

	function automatic void recompute_cpl();
		int q;
		q = gwwl_pkg::MAX_CHARS;
		if (cfg_glyph_width != 0) begin
			q = int'(cfg_text_width) / int'(cfg_glyph_width);
			if (q > gwwl_pkg::MAX_CHARS)
				q = gwwl_pkg::MAX_CHARS;
		end
		chars_per_line = 6'(q);
	endfunction

	// source side: hold an item until its transfer, then maybe idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				wrap_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
					s_tdata <= 8'($urandom);
				end
			end
		end
	end

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// sink side: check each result transfer against the oldest expectation
	always @(posedge clk) begin
		gwwl_pkg::result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (layout_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d data %h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = layout_expected.pop_front();
					compare_field("kind", int'(want.kind), int'(m_tuser));
					compare_field("line_num", int'(want.line_num), int'(m_tdata[2:0]));
					compare_field("column", int'(want.column), int'(m_tdata[8:3]));
					compare_field("glyph_code", int'(want.glyph), int'(m_tdata[16:9]));
					compare_field("draw_x", int'(want.dx), int'(m_tdata[32:17]));
					compare_field("draw_y", int'(want.dy), int'(m_tdata[48:33]));
					compare_field("last", int'(want.last), int'(m_tlast));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(gwwl_pkg::reg_index_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 11'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gwwl_pkg::REG_TEXT_WIDTH:   cfg_text_width = 11'(val);
			gwwl_pkg::REG_GLYPH_WIDTH:  cfg_glyph_width = 8'(val);
			gwwl_pkg::REG_GLYPH_HEIGHT: cfg_glyph_height = 8'(val);
			gwwl_pkg::REG_X_ORIGIN:     cfg_x = 11'(val);
			gwwl_pkg::REG_Y_ORIGIN:     cfg_y = 11'(val);
			gwwl_pkg::REG_CENTER:       cfg_center = val[0];
			default: ;
		endcase
		recompute_cpl();
	endtask

	task automatic apply_layout(int lw, int gw, int gh, int xo, int yo, int ca);
		write_reg(gwwl_pkg::REG_TEXT_WIDTH, lw);
		write_reg(gwwl_pkg::REG_GLYPH_WIDTH, gw);
		write_reg(gwwl_pkg::REG_GLYPH_HEIGHT, gh);
		write_reg(gwwl_pkg::REG_X_ORIGIN, xo);
		write_reg(gwwl_pkg::REG_Y_ORIGIN, yo);
		write_reg(gwwl_pkg::REG_CENTER, ca);
	endtask

	task automatic send_byte(int c);
		text_bytes.push_back(8'(c));
		items_queued++;
	endtask

	// wait until the block has gone quiet
	task automatic drain_and_wait();
		while (text_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
		while (layout_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one message of random words, now and then with a stray byte or no end
	task automatic queue_message();
		int words;
		int len;
		int c;
		int w;
		int k;
		words = $urandom_range(1, 7);
		for (w = 0; w < words; w++) begin
			if ($urandom_range(15) == 0)
				send_byte($urandom_range(255));
			if ($urandom_range(7) == 0)
				len = $urandom_range(1, gwwl_pkg::MAX_CHARS + 2);
			else
				len = $urandom_range(1, int'(chars_per_line) + 2);
			for (k = 0; k < len; k++) begin
				c = $urandom_range(1, 254);
				if (c >= gwwl_pkg::CHAR_SPACE)
					c++;
				send_byte(c);
			end
			repeat ($urandom_range(1, 2)) send_byte(gwwl_pkg::CHAR_SPACE);
		end
		if ($urandom_range(9) != 0)
			send_byte(gwwl_pkg::CHAR_END);
	endtask

	task automatic random_layout();
		int gw;
		int lw;
		int goal;
		case ($urandom_range(9))
			0: begin
				gw = 0;
				lw = $urandom_range(2047);
			end
			1: begin
				gw = $urandom_range(8, 255);
				lw = $urandom_range(0, 7);
			end
			default: begin
				gw = $urandom_range(1, 255);
				goal = $urandom_range(1, 10);
				lw = goal * gw + $urandom_range(0, gw - 1);
				if (lw > 2047)
					lw = 2047;
			end
		endcase
		apply_layout(lw, gw, $urandom_range(255), $urandom_range(2047), $urandom_range(2047),
			$urandom_range(1));
	endtask

	// stimulus
	initial begin
		int seq[$];
		int phase;
		int start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three glyphs per line, far origins: repeated spaces, cut word, four full lines,
		// then words past the last line are discarded
		apply_layout(24, 8, 255, 2047, 2047, 1);
		seq = '{32, 32, 1, 255, 66, 67, 32, 88, 32, 89, 32, 87, 32, 85, 32, 84, 32, 83,
			32, 82, 0};
		foreach (seq[i]) send_byte(seq[i]);
		drain_and_wait();

		// line narrower than one glyph drops everything
		apply_layout(3, 4, 1, 5, 6, 0);
		seq = '{65, 32, 66, 0};
		foreach (seq[i]) send_byte(seq[i]);
		drain_and_wait();

		// zero glyph width, then a buffered word cut by a narrower line
		apply_layout(2047, 0, 0, 0, 0, 1);
		seq = '{81, 32, 75, 76, 77};
		foreach (seq[i]) send_byte(seq[i]);
		drain_and_wait();
		write_reg(gwwl_pkg::REG_TEXT_WIDTH, 16);
		write_reg(gwwl_pkg::REG_GLYPH_WIDTH, 8);
		seq = '{32, 0};
		foreach (seq[i]) send_byte(seq[i]);
		drain_and_wait();

		// random messages over changing layouts
		start = items_queued;
		for (phase = 0; items_queued - start < 280; phase++) begin
			if (items_queued - start < 93) begin
				send_idle_pct = 10;
				recv_idle_pct = 87;
			end else if (items_queued - start < 187) begin
				send_idle_pct = 87;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 0)
				apply_layout(2047, 255, 255, 2047, 2047, 1);
			else if (phase == 1)
				apply_layout(1, 1, 0, 0, 0, 0);
			else
				random_layout();
			while (items_queued - start < (phase + 1) * 35)
				queue_message();
			drain_and_wait();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && layout_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
